// ----- sv/txcw_pkg.sv -----
// Shared types and constants for the text console character writer.
`default_nettype none

package txcw_pkg;

   // Field and register widths fixed by the port definition
   localparam int CHAR_W      = 8;
   localparam int CELL_W      = 16;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int COLS_REG_W  = 7;
   localparam int ROWS_REG_W  = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register reset values
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd80;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 5'd25;

   // Register index, taken from paddr[2]
   localparam logic REG_COLS = 1'b0;
   localparam logic REG_ROWS = 1'b1;

   // Item modes
   localparam logic MODE_PUT  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;

   localparam int TAB_STEP = 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

// ----- sv/txcw_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module txcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/text_console_char_writer.sv -----
// Teletype-style console writer over a ring-scrolled text screen memory.
//
//   channel   direction  handshake             word
//   req_      in         req_valid/req_stall   mode, char, attribute, read row/col
//   rsp_      out        rsp_valid/rsp_stall   cursor, read cell, scroll flag
//   csr_      in/out     psel/penable/pready   cols_in_use at 0x0, rows_in_use at 0x4
//
// Non-scrolling put: result loaded on accept. Read: waits in ST_READ for RAM data.
// Scrolling put: the new bottom row is cleared one cell a cycle.
// After reset the screen RAM is cleared one cell a cycle, all ROWS*COLS cells,
// with req_stall high; CSR writes are taken throughout.
// A result waiting under rsp_stall does not block the next word unless that
// word's result needs the output register; then the block holds until it drains.
`default_nettype none

module text_console_char_writer #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [txcw_pkg::CHAR_W-1:0]         req_char_code,
   input  logic [txcw_pkg::CHAR_W-1:0]         req_attribute,
   input  logic [txcw_pkg::ROW_FIELD_W-1:0]    req_read_row,
   input  logic [txcw_pkg::COL_FIELD_W-1:0]    req_read_col,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [txcw_pkg::ROW_FIELD_W-1:0]    rsp_cursor_row,
   output logic [txcw_pkg::COL_FIELD_W-1:0]    rsp_cursor_col,
   output logic [txcw_pkg::CHAR_W-1:0]         rsp_cell_char,
   output logic [txcw_pkg::CHAR_W-1:0]         rsp_cell_attr,
   output logic                                rsp_scrolled,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [txcw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [txcw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [txcw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import txcw_pkg::*;

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLS + TAB_STEP);
   localparam int RW    = $clog2(ROWS + 2);
   localparam int OW    = $clog2(ROWS);
   localparam int SCW   = $clog2(COLS);
   localparam logic [OW:0] ROWS_S = (OW + 1)'(ROWS);

   // Registers
   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ctr_ff, clr_ctr_in;
   logic [SCW-1:0]          scr_ctr_ff, scr_ctr_in;
   logic [RW-1:0]           cur_row_ff, cur_row_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in;
   logic [OW-1:0]           off_ff, off_in;
   logic [OW-1:0]           clr_row_ff, clr_row_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [CHAR_W-1:0]       pend_char_ff, pend_char_in;
   logic [CHAR_W-1:0]       pend_attr_ff, pend_attr_in;
   logic                    pend_scr_ff, pend_scr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_FIELD_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_FIELD_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [CHAR_W-1:0]       rsp_attr_ff, rsp_attr_in;
   logic                    rsp_scr_ff, rsp_scr_in;
   logic [COLS_REG_W-1:0]   cols_ff, cols_in;
   logic [ROWS_REG_W-1:0]   rows_ff, rows_in;

   // Combinational
   logic                    accept;
   logic                    out_free;
   logic                    load;
   logic [CHAR_W-1:0]       load_char;
   logic [CHAR_W-1:0]       load_attr;
   logic                    load_scr;
   logic [CW-1:0]           eff_w;
   logic [CW-1:0]           wm1;
   logic [RW-1:0]           eff_h;
   logic [CW-1:0]           tab_col;
   logic [CW-1:0]           col_a;
   logic [CW-1:0]           col_b;
   logic [RW-1:0]           row_a;
   logic [RW-1:0]           row_b;
   logic [RW-1:0]           row_c;
   logic                    is_char;
   logic                    wr_ok;
   logic                    rd_ok;
   logic                    put_scroll;
   logic [OW-1:0]           off_next;
   logic [OW-1:0]           lrow;
   logic [OW-1:0]           acc_row;
   logic [OW-1:0]           clr_lrow;
   logic [OW-1:0]           row_sel;
   logic [AW-1:0]           col_sel;
   logic [AW-1:0]           cell_addr;
   logic [CELL_W-1:0]       rd_cell;
   logic                    cfg_wr;

   logic                    ram_we;
   logic [AW-1:0]           ram_addr;
   logic [CELL_W-1:0]       ram_wdata;
   logic [CELL_W-1:0]       ram_rdata;

   // Logical row to physical row in the ring
   function automatic logic [OW-1:0] phys_of(input logic [OW-1:0] lr,
                                             input logic [OW-1:0] base);
      logic [OW:0] sum;
      sum = {1'b0, lr} + {1'b0, base};
      return (sum >= ROWS_S) ? OW'(sum - ROWS_S) : OW'(sum);
   endfunction

   txcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // CSR port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_COLS: cols_in = csr_pwdata[COLS_REG_W-1:0];
            REG_ROWS: rows_in = csr_pwdata[ROWS_REG_W-1:0];
         endcase
      end
      unique case (csr_paddr[2])
         REG_COLS: csr_prdata = CSR_DATA_W'(cols_ff);
         REG_ROWS: csr_prdata = CSR_DATA_W'(rows_ff);
      endcase
   end

   // Sequencer and datapath
   always_comb begin
      // clamp the widths in use to 1..COLS and 1..ROWS
      if (cols_ff == '0) begin
         eff_w = CW'(1);
      end else if (32'(cols_ff) > COLS) begin
         eff_w = CW'(COLS);
      end else begin
         eff_w = CW'(cols_ff);
      end
      if (rows_ff == '0) begin
         eff_h = RW'(1);
      end else if (32'(rows_ff) > ROWS) begin
         eff_h = RW'(ROWS);
      end else begin
         eff_h = RW'(rows_ff);
      end
      wm1 = eff_w - CW'(1);

      accept   = req_valid && (state_ff == ST_IDLE);
      out_free = !rsp_valid_ff || !rsp_stall;

      // cursor motion for a put
      col_a   = cur_col_ff;
      row_a   = cur_row_ff;
      is_char = 1'b0;
      tab_col = cur_col_ff + CW'(TAB_STEP);
      unique case (req_char_code)
         CH_CR: begin
            col_a = '0;
         end
         CH_LF: begin
            col_a = '0;
            row_a = cur_row_ff + RW'(1);
         end
         CH_BS: begin
            if (cur_col_ff == '0) begin
               if (cur_row_ff != '0) begin
                  row_a = cur_row_ff - RW'(1);
               end
               col_a = wm1;
            end else begin
               col_a = cur_col_ff - CW'(1);
            end
         end
         CH_TAB: begin
            // wrap past the stride, not the width in use
            if (tab_col > CW'(COLS)) begin
               col_a = tab_col - CW'(COLS);
               row_a = cur_row_ff + RW'(1);
            end else begin
               col_a = tab_col;
            end
         end
         default: begin
            is_char = 1'b1;
            col_a   = cur_col_ff + CW'(1);
         end
      endcase
      if (col_a > wm1) begin
         col_b = '0;
         row_b = row_a + RW'(1);
      end else begin
         col_b = col_a;
         row_b = row_a;
      end
      put_scroll = (row_b >= eff_h);
      row_c      = put_scroll ? (eff_h - RW'(1)) : row_b;
      wr_ok      = is_char && (cur_row_ff < RW'(ROWS)) && (cur_col_ff < CW'(COLS));
      rd_ok      = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLS);

      off_next = (off_ff == OW'(ROWS - 1)) ? '0 : (off_ff + OW'(1));
      lrow     = (req_mode == MODE_READ) ? OW'(req_read_row) : OW'(cur_row_ff);
      acc_row  = phys_of(lrow, off_ff);
      clr_lrow = OW'(eff_h - RW'(1));

      if (state_ff == ST_SCROLL) begin
         row_sel = clr_row_ff;
         col_sel = AW'(scr_ctr_ff);
      end else begin
         row_sel = acc_row;
         col_sel = (req_mode == MODE_READ) ? AW'(req_read_col) : AW'(cur_col_ff);
      end
      cell_addr = AW'(row_sel) * AW'(COLS) + col_sel;
      rd_cell   = rd_ok_ff ? ram_rdata : '0;

      // defaults: hold
      state_in     = state_ff;
      clr_ctr_in   = clr_ctr_ff;
      scr_ctr_in   = scr_ctr_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      off_in       = off_ff;
      clr_row_in   = clr_row_ff;
      rd_ok_in     = rd_ok_ff;
      pend_char_in = pend_char_ff;
      pend_attr_in = pend_attr_ff;
      pend_scr_in  = pend_scr_ff;
      ram_we       = 1'b0;
      ram_addr     = cell_addr;
      ram_wdata    = '0;
      load         = 1'b0;
      load_char    = pend_char_ff;
      load_attr    = pend_attr_ff;
      load_scr     = pend_scr_ff;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ctr_ff;
            if (clr_ctr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_ctr_in = clr_ctr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            load_char = '0;
            load_attr = '0;
            load_scr  = 1'b0;
            if (accept) begin
               rd_ok_in     = rd_ok;
               pend_char_in = '0;
               pend_attr_in = '0;
               pend_scr_in  = 1'b0;
               if (req_mode == MODE_READ) begin
                  state_in = ST_READ;
               end else begin
                  cur_col_in = col_b;
                  cur_row_in = row_c;
                  ram_we     = wr_ok;
                  ram_wdata  = {req_attribute, req_char_code};
                  if (put_scroll) begin
                     off_in      = off_next;
                     clr_row_in  = phys_of(clr_lrow, off_next);
                     pend_scr_in = 1'b1;
                     scr_ctr_in  = '0;
                     state_in    = ST_SCROLL;
                  end else if (out_free) begin
                     load = 1'b1;
                  end else begin
                     state_in = ST_DELIVER;
                  end
               end
            end
         end
         ST_READ: begin
            pend_char_in = rd_cell[CHAR_W-1:0];
            pend_attr_in = rd_cell[CELL_W-1:CHAR_W];
            load_char    = rd_cell[CHAR_W-1:0];
            load_attr    = rd_cell[CELL_W-1:CHAR_W];
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_SCROLL: begin
            ram_we = 1'b1;
            if (scr_ctr_ff == SCW'(COLS - 1)) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DELIVER;
               end
            end else begin
               scr_ctr_in = scr_ctr_ff + SCW'(1);
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase

      // output register
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_scr_in   = rsp_scr_ff;
      if (load) begin
         rsp_row_in  = ROW_FIELD_W'(cur_row_in);
         rsp_col_in  = COL_FIELD_W'(cur_col_in);
         rsp_char_in = load_char;
         rsp_attr_in = load_attr;
         rsp_scr_in  = load_scr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ctr_ff   <= '0;
         scr_ctr_ff   <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ctr_ff   <= clr_ctr_in;
         scr_ctr_ff   <= scr_ctr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_row_ff   <= clr_row_in;
      rd_ok_ff     <= rd_ok_in;
      pend_char_ff <= pend_char_in;
      pend_attr_ff <= pend_attr_in;
      pend_scr_ff  <= pend_scr_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   // Checks
   a_col_in_stride: assert property (@(posedge clock) disable iff (reset)
      cur_col_ff < CW'(COLS))
      else $error("cursor column left the row stride");

   a_row_on_screen: assert property (@(posedge clock) disable iff (reset)
      cur_row_ff < RW'(ROWS))
      else $error("cursor row left the screen");

   a_scroll_flagged: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCROLL |-> pend_scr_ff)
      else $error("row clear running without a pending scroll flag");

   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_READ |=> state_ff == ST_READ)
      else $error("read word did not wait for RAM data");

endmodule

`default_nettype wire
